/* src/nhl_pkg.sv */
`default_nettype none

package nhl_pkg;

    // Nibble codes on the link
    localparam logic [3:0] NIB_B     = 4'hB;
    localparam logic [3:0] NIB_E     = 4'hE;
    localparam logic [3:0] DIGIT_MAX = 4'd9;

    // Reset value of the timeout limit register
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // Send phases: 0 is receive mode, 1..8 walk E,d3,E,d2,E,d1,E,d0
    localparam logic [3:0] PHASE_RECV = 4'd0;
    localparam logic [3:0] PHASE_LAST = 4'd8;

    // Status code reported for a completed send
    localparam logic [3:0] STATUS_OK = 4'd0;

    // Link state carried from one poll to the next
    typedef struct packed {
        logic [3:0]       phase;
        logic             armed;
        logic [3:0][3:0]  digits;
        logic [2:0]       count;
        logic [15:0]      timeout_left;
        logic [3:0]       driven;
    } t_state;

    // One result word
    typedef struct packed {
        logic [3:0]       drive_nibble;
        logic             message_valid;
        logic [3:0][3:0]  digits;
        logic             send_done;
        logic [3:0]       send_status;
    } t_result;

    // Value the partner must echo in a send phase: E on odd phases,
    // otherwise the stored digit counted down from the last slot
    function automatic logic [3:0] phase_target(input logic [3:0] phase,
                                                input logic [3:0][3:0] digits);
        logic [3:0] slot_calc;
        slot_calc = (PHASE_LAST - phase) >> 1;
        if (phase[0]) begin
            return NIB_E;
        end
        return digits[slot_calc[1:0]];
    endfunction

endpackage

`default_nettype wire

/* src/nhl_step.sv */
`default_nettype none

module nhl_step (
    input  wire nhl_pkg::t_state  i_state,
    input  wire logic [3:0]       i_nib,
    input  wire logic [15:0]      i_limit,
    output nhl_pkg::t_state       o_state,
    output nhl_pkg::t_result      o_result
);

    logic [3:0]  tgt;
    logic [3:0]  phase_inc;
    logic [15:0] left_dec;

    assign tgt       = nhl_pkg::phase_target(i_state.phase, i_state.digits);
    assign phase_inc = i_state.phase + 4'd1;
    assign left_dec  = i_state.timeout_left - 16'd1;

    // Update link state and build the result word for one poll
    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_state.phase == nhl_pkg::PHASE_RECV || i_state.phase > nhl_pkg::PHASE_LAST) begin
            // receive mode
            o_state.phase = nhl_pkg::PHASE_RECV;
            if (i_nib == nhl_pkg::NIB_E) begin
                o_state.armed  = 1'b1;
                o_state.driven = nhl_pkg::NIB_E;
            end else if (i_nib == nhl_pkg::NIB_B) begin
                o_state.driven = nhl_pkg::NIB_B;
                if (i_state.count != 3'd0) begin
                    o_result.message_valid = 1'b1;
                    o_result.digits        = i_state.digits;
                    o_state.count          = 3'd0;
                    o_state.timeout_left   = i_limit;
                    o_state.phase          = 4'd1;
                end
            end else if (i_nib <= nhl_pkg::DIGIT_MAX) begin
                // store an armed digit unless four are already held
                if (i_state.armed && i_state.count < 3'd4) begin
                    o_state.armed                       = 1'b0;
                    o_state.digits[i_state.count[1:0]]  = i_nib;
                    o_state.count                       = i_state.count + 3'd1;
                    o_state.driven                      = i_nib;
                end
            end
        end else begin
            // send mode: advance on echo, otherwise burn timeout budget
            if (i_nib == tgt) begin
                if (i_state.phase == nhl_pkg::PHASE_LAST) begin
                    o_state.driven       = nhl_pkg::NIB_B;
                    o_state.phase        = nhl_pkg::PHASE_RECV;
                    o_result.send_done   = 1'b1;
                    o_result.send_status = nhl_pkg::STATUS_OK;
                end else begin
                    o_state.phase  = phase_inc;
                    o_state.driven = nhl_pkg::phase_target(phase_inc, i_state.digits);
                end
            end else begin
                o_state.driven       = tgt;
                o_state.timeout_left = left_dec;
                if (left_dec == 16'd0) begin
                    o_result.send_done   = 1'b1;
                    o_result.send_status = i_state.phase;
                    o_state.phase        = nhl_pkg::PHASE_RECV;
                end
            end
        end
        o_result.drive_nibble = o_state.driven;
    end

endmodule

`default_nettype wire

/* src/nibble_handshake_link_core.sv */
`default_nettype none

// Nibble handshake link: each accepted input word is one poll of the
// partner's four lines and yields exactly one result word with the value
// now driven, a completed message (up to four digits) if one ended on this
// poll, and send completion or timeout status. A new poll is accepted every
// clock cycle while results are taken. A result word becomes valid on the
// outputs once its poll has passed from the input register through the
// single compare-and-update step into the result register. With the output
// stalled, the input register holds one more poll and then input ready
// drops. The timeout limit is written through i_cfg_we/i_cfg_wdata; the
// user must write it only while the link is idle, as the block does not
// enforce this. It resets to 1000; a limit of 0 behaves as 65536 misses.
module nibble_handshake_link_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [3:0]  i_partner_nibble,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [3:0]       o_drive_nibble,
    output logic             o_message_valid,
    output logic [3:0]       o_digit_first,
    output logic [3:0]       o_digit_second,
    output logic [3:0]       o_digit_third,
    output logic [3:0]       o_digit_fourth,
    output logic             o_send_done,
    output logic [3:0]       o_send_status
);

    logic [15:0]       r_limit;
    logic              r_in_valid;
    logic [3:0]        r_in_nib;
    logic              r_out_valid;
    nhl_pkg::t_result  r_out;
    nhl_pkg::t_state   r_state;
    nhl_pkg::t_state   n_state;
    nhl_pkg::t_result  n_out;
    logic              advance;

    // Move the held word to the result register when that slot frees up
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Hold the timeout limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= nhl_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_nib <= i_partner_nibble;
        end
    end

    nhl_step u_step (
        .i_state  (r_state),
        .i_nib    (r_in_nib),
        .i_limit  (r_limit),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Advance link state once per poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_drive_nibble  = r_out.drive_nibble;
    assign o_message_valid = r_out.message_valid;
    assign o_digit_first   = r_out.digits[0];
    assign o_digit_second  = r_out.digits[1];
    assign o_digit_third   = r_out.digits[2];
    assign o_digit_fourth  = r_out.digits[3];
    assign o_send_done     = r_out.send_done;
    assign o_send_status   = r_out.send_status;

endmodule

`default_nettype wire

/* src/nhl_checker.sv */
`default_nettype none

module nhl_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic [3:0] i_drive_nibble,
    input  wire logic       i_message_valid,
    input  wire logic [3:0] i_digit_first,
    input  wire logic       i_send_done,
    input  wire logic [3:0] i_send_status
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_drive_nibble)
            && $stable(i_send_status))
        else $error("result word changed while stalled");

    // A finished message always shows the B echo
    a_msg_drive_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_message_valid |-> i_drive_nibble == nhl_pkg::NIB_B)
        else $error("message reported without B on the lines");

    // A message and a send end never share one poll
    a_msg_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_message_valid && i_send_done))
        else $error("message and send end on the same poll");

    // A successful send drives B; status is zero unless a send ended
    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (!i_send_done || i_send_status == nhl_pkg::STATUS_OK)
            && !i_message_valid
        |-> (i_send_done ? i_drive_nibble == nhl_pkg::NIB_B
                         : i_send_status == nhl_pkg::STATUS_OK)
            && i_digit_first == 4'd0)
        else $error("status or digits set outside their event");

    // Timeout status names a real phase
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_send_done |-> i_send_status <= nhl_pkg::PHASE_LAST)
        else $error("send status out of range");

endmodule

bind nibble_handshake_link_core nhl_checker u_nhl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .i_drive_nibble  (o_drive_nibble),
    .i_message_valid (o_message_valid),
    .i_digit_first   (o_digit_first),
    .i_send_done     (o_send_done),
    .i_send_status   (o_send_status)
);

`default_nettype wire

/* sim/testbench.sv */
`default_nettype none

module testbench;

    localparam logic [3:0] PHASE_FIRST = 4'd1;
    localparam int         MAX_REPORTS = 10;

    // Track link state per accepted poll and queue the result word it must yield
    class link_scoreboard;
        logic [15:0]      limit;
        logic [3:0]       phase;
        logic             armed;
        logic [3:0]       digits [4];
        logic [2:0]       count;
        logic [15:0]      budget;
        logic [3:0]       driven;
        nhl_pkg::t_result exp_q[$];
        int unsigned      errors;
        int unsigned      polls;
        int unsigned      messages;
        int unsigned      sends_ok;
        int unsigned      timeouts;
        logic [8:0]       timeout_phases;

        function new();
            limit = nhl_pkg::TIMEOUT_RESET;
            phase = nhl_pkg::PHASE_RECV;
            armed = 1'b0;
            foreach (digits[i]) digits[i] = 4'd0;
            count = 3'd0;
            budget = 16'd0;
            driven = 4'd0;
            timeout_phases = '0;
        endfunction

        function void set_limit(logic [15:0] value);
            limit = value;
        endfunction

        // Value the partner has to echo in the current send phase
        function logic [3:0] target();
            logic [3:0] slot;
            slot = (nhl_pkg::PHASE_LAST - phase) >> 1;
            if (phase[0]) begin
                return nhl_pkg::NIB_E;
            end
            return digits[slot[1:0]];
        endfunction

        function int pending();
            return exp_q.size();
        endfunction

        // Advance the link by one accepted poll and queue the expected word
        function void note_poll(logic [3:0] nib);
            nhl_pkg::t_result res;
            logic [3:0]       tgt;
            res = '0;
            polls++;
            if (phase == nhl_pkg::PHASE_RECV || phase > nhl_pkg::PHASE_LAST) begin
                phase = nhl_pkg::PHASE_RECV;
                if (nib == nhl_pkg::NIB_E) begin
                    armed = 1'b1;
                    driven = nhl_pkg::NIB_E;
                end else if (nib == nhl_pkg::NIB_B) begin
                    driven = nhl_pkg::NIB_B;
                    if (count != 3'd0) begin
                        res.message_valid = 1'b1;
                        for (int i = 0; i < 4; i++) res.digits[i] = digits[i];
                        count = 3'd0;
                        budget = limit;
                        phase = PHASE_FIRST;
                        messages++;
                    end
                end else if (nib <= nhl_pkg::DIGIT_MAX) begin
                    // drop the digit when unarmed or when four are already held
                    if (armed && count < 3'd4) begin
                        armed = 1'b0;
                        digits[count[1:0]] = nib;
                        count++;
                        driven = nib;
                    end
                end
            end else begin
                tgt = target();
                if (nib == tgt) begin
                    phase++;
                    if (phase > nhl_pkg::PHASE_LAST) begin
                        driven = nhl_pkg::NIB_B;
                        phase = nhl_pkg::PHASE_RECV;
                        res.send_done = 1'b1;
                        res.send_status = nhl_pkg::STATUS_OK;
                        sends_ok++;
                    end else begin
                        driven = target();
                    end
                end else begin
                    // budget is shared by the whole send and wraps from zero
                    driven = tgt;
                    budget--;
                    if (budget == 16'd0) begin
                        res.send_done = 1'b1;
                        res.send_status = phase;
                        timeout_phases[phase] = 1'b1;
                        timeouts++;
                        phase = nhl_pkg::PHASE_RECV;
                    end
                end
            end
            res.drive_nibble = driven;
            exp_q.push_back(res);
        endfunction

        // Compare one accepted result word against the oldest expectation
        function void check_result(nhl_pkg::t_result got);
            nhl_pkg::t_result want_r;
            bit               bad;
            if (exp_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: unexpected result word: drive=%h msg=%b done=%b",
                             got.drive_nibble, got.message_valid, got.send_done);
                return;
            end
            want_r = exp_q.pop_front();
            bad = (got.drive_nibble !== want_r.drive_nibble)
                || (got.message_valid !== want_r.message_valid)
                || (got.digits[0] !== want_r.digits[0])
                || (got.digits[1] !== want_r.digits[1])
                || (got.digits[2] !== want_r.digits[2])
                || (got.digits[3] !== want_r.digits[3])
                || (got.send_done !== want_r.send_done)
                || (got.send_status !== want_r.send_status);
            if (bad) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("ERROR: expected drive=%h msg=%b dig=%h %h %h %h done=%b st=%0d",
                             want_r.drive_nibble, want_r.message_valid, want_r.digits[0],
                             want_r.digits[1], want_r.digits[2], want_r.digits[3],
                             want_r.send_done, want_r.send_status);
                    $display("       actual   drive=%h msg=%b dig=%h %h %h %h done=%b st=%0d",
                             got.drive_nibble, got.message_valid, got.digits[0],
                             got.digits[1], got.digits[2], got.digits[3],
                             got.send_done, got.send_status);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = 16'd0;
    logic        i_in_valid = 1'b0;
    logic [3:0]  i_partner_nibble = 4'd0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [3:0]  o_drive_nibble;
    logic        o_message_valid;
    logic [3:0]  o_digit_first;
    logic [3:0]  o_digit_second;
    logic [3:0]  o_digit_third;
    logic [3:0]  o_digit_fourth;
    logic        o_send_done;
    logic [3:0]  o_send_status;

    link_scoreboard sb = new();
    bit             idle_on = 1'b1;
    int             stall_left = 0;
    int             want_digits = 1;

    nibble_handshake_link_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_partner_nibble (i_partner_nibble),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_drive_nibble   (o_drive_nibble),
        .o_message_valid  (o_message_valid),
        .o_digit_first    (o_digit_first),
        .o_digit_second   (o_digit_second),
        .o_digit_third    (o_digit_third),
        .o_digit_fourth   (o_digit_fourth),
        .o_send_done      (o_send_done),
        .o_send_status    (o_send_status)
    );

    // Generate the clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Drive result ready: random idling, or a long hold-off when requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= !(idle_on && $urandom_range(0, 99) < 37);
            end
        end
    end

    // Check each accepted result word
    always @(posedge i_clk) begin
        nhl_pkg::t_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.drive_nibble  = o_drive_nibble;
            got.message_valid = o_message_valid;
            got.digits[0]     = o_digit_first;
            got.digits[1]     = o_digit_second;
            got.digits[2]     = o_digit_third;
            got.digits[3]     = o_digit_fourth;
            got.send_done     = o_send_done;
            got.send_status   = o_send_status;
            sb.check_result(got);
        end
    end

    // Offer one poll word, hold it until accepted, then note it
    task automatic send_poll(input logic [3:0] nib);
        if (idle_on && $urandom_range(0, 99) < 37) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (idle_on && $urandom_range(0, 99) < 37);
        end
        i_in_valid <= 1'b1;
        i_partner_nibble <= nib;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_poll(nib);
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Write the timeout limit while the link is idle
    task automatic write_limit(input logic [15:0] value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_limit(value);
    endtask

    // Choose the next poll: mostly well-formed messages and echoes, some noise
    function automatic logic [3:0] pick_poll(int miss_pct);
        if (sb.phase != nhl_pkg::PHASE_RECV) begin
            if ($urandom_range(0, 99) < miss_pct) return 4'($urandom);
            return sb.target();
        end
        if (sb.count == 3'd0) want_digits = $urandom_range(1, 4);
        if ($urandom_range(0, 99) < 15) return 4'($urandom);
        if (sb.count < want_digits) begin
            return sb.armed ? 4'($urandom_range(0, 9)) : nhl_pkg::NIB_E;
        end
        // occasionally push digits beyond the chosen count, dropped once four are held
        if ($urandom_range(0, 99) < 20) begin
            return sb.armed ? 4'($urandom_range(0, 9)) : nhl_pkg::NIB_E;
        end
        return nhl_pkg::NIB_B;
    endfunction

    task automatic run_random(input int n, input int miss_pct);
        repeat (n) send_poll(pick_poll(miss_pct));
    endtask

    // Main sequence
    initial begin
        logic [3:0] directed_polls [$];
        directed_polls = '{4'h5, 4'hA, 4'hC, 4'hD, 4'hF, nhl_pkg::NIB_B,
                           nhl_pkg::NIB_E, 4'h0, nhl_pkg::NIB_E, 4'h9,
                           nhl_pkg::NIB_E, 4'h3, nhl_pkg::NIB_E, 4'h7,
                           nhl_pkg::NIB_E, 4'h9, nhl_pkg::NIB_B};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: ignored values, empty B, full buffer, then a send with one miss
        foreach (directed_polls[i]) send_poll(directed_polls[i]);
        send_poll(4'hF);
        while (sb.phase != nhl_pkg::PHASE_RECV) send_poll(sb.target());

        write_limit(16'd1);
        run_random(250, 30);

        write_limit(16'd0);
        run_random(250, 20);

        // stretch without any idling on either side
        write_limit(16'hFFFF);
        idle_on = 1'b0;
        run_random(300, 20);
        idle_on = 1'b1;

        write_limit(16'($urandom_range(2, 6)));
        run_random(400, 40);

        // hold results off while polls keep coming, so the input backs up
        stall_left = 80;
        run_random(60, 25);

        write_limit(nhl_pkg::TIMEOUT_RESET);
        run_random(700, 15);

        drain();
        repeat (10) @(posedge i_clk);

        $display("Covered %0d polls: %0d messages, %0d sends completed, %0d timed out",
                 sb.polls, sb.messages, sb.sends_ok, sb.timeouts);
        $display("Timeout phases seen (bit per phase): %b, mismatches: %0d",
                 sb.timeout_phases[8:1], sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("nibble_handshake_link_core verification clean");
        end else begin
            $display("nibble_handshake_link_core verification failed");
        end
        $finish;
    end

    // End the run if it hangs
    initial begin
        #4000000;
        $display("Timeout with %0d words still expected", sb.pending());
        $display("nibble_handshake_link_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
src/nhl_pkg.sv
src/nhl_step.sv
src/nibble_handshake_link_core.sv
src/nhl_checker.sv
sim/testbench.sv
